// ===== sv/masked_column_distance_top_defines.svh =====
// Assertion shorthands for the masked column distance block.
// Each use expects clk and rst_n in scope.
`ifndef MASKED_COLUMN_DISTANCE_TOP_DEFINES_SVH
`define MASKED_COLUMN_DISTANCE_TOP_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define MCD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/mcd_pkg.sv =====
package mcd_pkg;

  // Field widths
  localparam int VAL_W   = 16;
  localparam int SUM_W   = 48;
  localparam int COUNT_W = 13;
  localparam int MODE_W  = 2;
  localparam int TERM_W  = 2 * VAL_W;
  // Widest product: row count times difference sum
  localparam int PROD_W  = COUNT_W + SUM_W;

  // Largest value a row counter holds
  localparam int COUNT_MAX = 8191;

  localparam logic [SUM_W-1:0] DIST_MAX = {SUM_W{1'b1}};

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_MODE = '0;

  // Distance modes; the unused code behaves as mean square
  localparam logic [MODE_W-1:0] MODE_EUCLID    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEANSQ    = 2'd2;

  // Request from the accumulator to the arithmetic unit
  typedef struct packed {
    logic               start;
    logic               ack;
    logic [MODE_W-1:0]  mode;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] valids;
  } mcd_req_t;

  // Response from the arithmetic unit
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] distance;
    logic             no_valid;
    logic             sat;
  } mcd_rsp_t;

endpackage

// ===== sv/mcd_in_if.sv =====
interface mcd_in_if;
  import mcd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_a;
  logic signed [VAL_W-1:0] value_b;
  logic                    missing_a;
  logic                    missing_b;
  logic                    last_row;

  modport source (
    output valid, value_a, value_b, missing_a, missing_b, last_row,
    input  ready
  );

  modport sink (
    input  valid, value_a, value_b, missing_a, missing_b, last_row,
    output ready
  );

endinterface

// ===== sv/mcd_out_if.sv =====
interface mcd_out_if;
  import mcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance;
  logic             no_valid_rows;
  logic             saturated;

  modport source (
    output valid, distance, no_valid_rows, saturated,
    input  ready
  );

  modport sink (
    input  valid, distance, no_valid_rows, saturated,
    output ready
  );

endinterface

// ===== sv/masked_column_distance_top.sv =====
// Row item: accepted, then accumulated in the next cycle before another is taken.
// Last row item: the result comes from one shared add/subtract unit stepping
// through a 13-step multiply (Euclidean and Manhattan modes), a 61-step divide
// and a 31-step square root (Euclidean mode).
// Reset (synchronous, active low) clears the sums, counts, mode and output valid.
`include "masked_column_distance_top_defines.svh"

module masked_column_distance_top #(
  parameter int MAX_ROWS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mcd_in_if.sink                      in_chan,
  mcd_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcd_pkg::DATA_W-1:0]  pwdata,
  output logic [mcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import mcd_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < COUNT_MAX) ? MAX_ROWS : COUNT_MAX;

  typedef enum logic [1:0] {T_IDLE, T_ROW, T_START, T_CALC} state_t;

  state_t             state_r;
  logic [MODE_W-1:0]  mode_r;
  logic [SUM_W-1:0]   sum_r;
  logic [COUNT_W-1:0] row_cnt_r;
  logic [COUNT_W-1:0] valid_cnt_r;
  logic [TERM_W-1:0]  term_r;
  logic               add_r;
  logic               last_r;
  logic               out_valid_r;
  logic [SUM_W-1:0]   out_dist_r;
  logic               out_none_r;
  logic               out_sat_r;

  logic               in_fire;
  logic               out_fire;
  logic               take;
  logic               cfg_wr;
  logic               count_en;
  logic               pair_ok;
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]     diff_neg;
  logic [VAL_W-1:0]   mag;
  logic [TERM_W-1:0]  mag_sq;
  logic [TERM_W-1:0]  term;
  mcd_req_t           arith_req;
  mcd_rsp_t           arith_rsp;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_MODE);
  assign prdata = (paddr[ADDR_W-1:2] == REG_MODE) ? DATA_W'(mode_r) : '0;

  // Handshakes
  assign in_chan.ready = (state_r == T_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_valid_r && out_chan.ready;
  assign take          = (state_r == T_CALC) && arith_rsp.done
                         && (!out_valid_r || out_chan.ready);

  // Row term: absolute or squared difference
  assign diff     = {in_chan.value_a[VAL_W-1], in_chan.value_a}
                  - {in_chan.value_b[VAL_W-1], in_chan.value_b};
  assign diff_neg = -diff;
  assign mag      = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
  assign mag_sq   = mag * mag;
  assign term     = (mode_r == MODE_MANHATTAN) ? TERM_W'(mag) : mag_sq;

  assign count_en = (row_cnt_r < COUNT_W'(ROW_LIMIT));
  assign pair_ok  = !in_chan.missing_a && !in_chan.missing_b;

  // Hold state, counts and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      mode_r      <= MODE_EUCLID;
      sum_r       <= '0;
      row_cnt_r   <= '0;
      valid_cnt_r <= '0;
      add_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mode_r <= pwdata[MODE_W-1:0];
      end
      if (take) begin
        out_valid_r <= 1'b1;
        out_dist_r  <= arith_rsp.distance;
        out_none_r  <= arith_rsp.no_valid;
        out_sat_r   <= arith_rsp.sat;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_fire) begin
            term_r  <= term;
            add_r   <= count_en && pair_ok;
            last_r  <= in_chan.last_row;
            state_r <= T_ROW;
            if (count_en) begin
              row_cnt_r <= row_cnt_r + 1'b1;
              if (pair_ok) begin
                valid_cnt_r <= valid_cnt_r + 1'b1;
              end
            end
          end
        end
        T_ROW: begin
          if (add_r) begin
            sum_r <= sum_r + SUM_W'(term_r);
          end
          state_r <= last_r ? T_START : T_IDLE;
        end
        T_START: begin
          // Unit latches the operands here; clear for the next column pair
          sum_r       <= '0;
          row_cnt_r   <= '0;
          valid_cnt_r <= '0;
          state_r     <= T_CALC;
        end
        T_CALC: begin
          if (take) begin
            state_r <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign arith_req.start  = (state_r == T_START);
  assign arith_req.ack    = take;
  assign arith_req.mode   = mode_r;
  assign arith_req.sum    = sum_r;
  assign arith_req.rows   = row_cnt_r;
  assign arith_req.valids = valid_cnt_r;

  mcd_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.distance      = out_dist_r;
  assign out_chan.no_valid_rows = out_none_r;
  assign out_chan.saturated     = out_sat_r;

  `MCD_ASSERT_ALWAYS(a_count_order, valid_cnt_r <= row_cnt_r, "valid rows exceed rows")
  `MCD_ASSERT_ALWAYS(a_row_limit, row_cnt_r <= COUNT_W'(ROW_LIMIT), "row count past limit")
  `MCD_ASSERT_IMPLY(a_take_done, take, arith_rsp.done, "result taken before unit done")
  `MCD_ASSERT_IMPLY(a_none_max, arith_rsp.done && arith_rsp.no_valid, arith_rsp.distance == DIST_MAX && !arith_rsp.sat, "empty pair not infinite")

endmodule

// ===== sv/mcd_arith.sv =====
module mcd_arith (
  input  logic              clk,
  input  logic              rst_n,
  input  mcd_pkg::mcd_req_t req,
  output mcd_pkg::mcd_rsp_t rsp
);
  import mcd_pkg::*;

  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam int ROOT_W = (PROD_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int DSH_W  = COUNT_W + 1;
  localparam int SSH_W  = REM_W + 2;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SQRT, S_DONE} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MODE_W-1:0]  mode_r;
  logic               none_r;
  logic [COUNT_W-1:0] mult_r;
  logic [COUNT_W-1:0] divisor_r;
  logic [PROD_W-1:0]  mcand_r;
  logic [PROD_W-1:0]  acc_r;
  logic [COUNT_W-1:0] rem_r;
  logic [RAD_W-1:0]   rad_r;
  logic [ROOT_W-1:0]  root_r;
  logic [REM_W-1:0]   sq_rem_r;

  logic [DSH_W-1:0]   div_sh;
  logic [SSH_W-1:0]   sq_sh;
  logic [REM_W-1:0]   trial;
  logic [PROD_W-1:0]  alu_a;
  logic [PROD_W-1:0]  alu_b;
  logic               alu_sub;
  logic [PROD_W-1:0]  alu_y;
  logic               alu_c;
  logic [PROD_W-1:0]  quo_nxt;
  logic [PROD_W-1:0]  res;
  logic               res_sat;

  // Shift in the next dividend bit and the next radicand pair
  assign div_sh  = {rem_r, acc_r[PROD_W-1]};
  assign sq_sh   = {sq_rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign quo_nxt = {acc_r[PROD_W-2:0], alu_c};

  // Pick operands for the shared adder/subtractor
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_MUL: begin
        alu_a = acc_r;
        alu_b = mcand_r;
      end
      S_DIV: begin
        alu_a   = PROD_W'(div_sh);
        alu_b   = PROD_W'(divisor_r);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = PROD_W'(sq_sh);
        alu_b   = PROD_W'(trial);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Shared unit: carry out on subtract means a >= b
  assign {alu_c, alu_y} = {1'b0, alu_a} + {1'b0, alu_b ^ {PROD_W{alu_sub}}}
                        + (PROD_W + 1)'(alu_sub);

  // Sequence multiply, divide and root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            mode_r    <= req.mode;
            mult_r    <= req.rows;
            divisor_r <= req.valids;
            mcand_r   <= PROD_W'(req.sum);
            rem_r     <= '0;
            if (req.valids == '0) begin
              none_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              none_r <= 1'b0;
              if (req.mode == MODE_EUCLID || req.mode == MODE_MANHATTAN) begin
                acc_r   <= '0;
                cnt_r   <= CNT_W'(COUNT_W - 1);
                state_r <= S_MUL;
              end else begin
                acc_r   <= PROD_W'(req.sum);
                cnt_r   <= CNT_W'(PROD_W - 1);
                state_r <= S_DIV;
              end
            end
          end
        end
        S_MUL: begin
          if (mult_r[0]) begin
            acc_r <= alu_y;
          end
          mcand_r <= mcand_r << 1;
          mult_r  <= mult_r >> 1;
          if (cnt_r == '0) begin
            cnt_r   <= CNT_W'(PROD_W - 1);
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DIV: begin
          rem_r <= alu_c ? alu_y[COUNT_W-1:0] : div_sh[COUNT_W-1:0];
          acc_r <= quo_nxt;
          if (cnt_r == '0) begin
            if (mode_r == MODE_EUCLID) begin
              rad_r    <= RAD_W'(quo_nxt);
              root_r   <= '0;
              sq_rem_r <= '0;
              cnt_r    <= CNT_W'(ROOT_W - 1);
              state_r  <= S_SQRT;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_SQRT: begin
          sq_rem_r <= alu_c ? alu_y[REM_W-1:0] : sq_sh[REM_W-1:0];
          root_r   <= {root_r[ROOT_W-2:0], alu_c};
          rad_r    <= rad_r << 2;
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DONE: begin
          if (req.ack) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Clip to the 48-bit range; an empty column pair reads as infinity
  assign res     = (mode_r == MODE_EUCLID) ? PROD_W'(root_r) : acc_r;
  assign res_sat = !none_r && (|res[PROD_W-1:SUM_W]);

  assign rsp.done     = (state_r == S_DONE);
  assign rsp.no_valid = none_r;
  assign rsp.sat      = res_sat;
  assign rsp.distance = (none_r || res_sat) ? DIST_MAX : res[SUM_W-1:0];

endmodule
